// ===== rtl/iasi_pkg.sv =====
// Shared types and constants for the indexed array store with insert.
package iasi_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_SET    = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_INSERT = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

// ===== rtl/iasi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iasi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/indexed_array_store_with_insert_core.sv =====
// Top level of the indexed array store: request sequencer, element count and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: in_req_type (get, set,
//   append, insert), in_position and in_word_in. The block takes one request at a
//   time and holds in_stall high from acceptance until its result is loaded.
//   Result channel (out_valid/out_stall) returns exactly one result per request:
//   out_word_out (read data of a good get, else zero), out_status and out_count_out.
//   Set, append and any refused request go from the check straight to the result; a get
//   first waits for the registered RAM read, and an insert first shifts count - position
//   entries up by one, since the single RAM port pair moves one entry per cycle from the back
//   of the array down to the insert point, then writes the new word there.
//   A new request is taken on the cycle after the result is loaded.
//   A stalled result holds in the output register; a finished request waits for
//   the register to drain before loading, and the block stays busy meanwhile.
//   Reset (rst_n low, synchronous) empties the store and drops any pending result;
//   array contents are not cleared, only entries below the count are ever read.
module indexed_array_store_with_insert_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  iasi_pkg::req_kind_t     in_req_type,
  input  logic [7:0]              in_position,
  input  logic signed [31:0]      in_word_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      out_word_out,
  output logic [1:0]              out_status,
  output logic [8:0]              out_count_out
);
  import iasi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GET_WAIT,
    S_SHIFT,
    S_INS_WR,
    S_FINISH
  } state_t;

  localparam int EXT_W = CNT_W + POS_W;

  state_t               state_r, state_nxt;
  req_kind_t            kind_r, kind_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    src_r, src_nxt;
  logic [WORD_W-1:0]    res_word_r, res_word_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [WORD_W-1:0]    ram_wr_data;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [WORD_W-1:0]    ram_rd_data;

  logic [EXT_W-1:0]     pos_ext;
  logic [EXT_W-1:0]     cnt_ext;
  logic [ADDR_W-1:0]    pos_addr;
  logic [ADDR_W-1:0]    cnt_addr;
  logic [ADDR_W-1:0]    last_addr;
  logic [CNT_W-1:0]     count_dec;
  logic [EXT_W-1:0]     count_wide;
  logic                 in_range;
  logic                 is_full;
  logic                 out_free;

  iasi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign pos_ext    = {{CNT_W{1'b0}}, pos_r};
  assign cnt_ext    = {{POS_W{1'b0}}, count_r};
  assign pos_addr   = pos_ext[ADDR_W-1:0];
  assign cnt_addr   = cnt_ext[ADDR_W-1:0];
  assign count_dec  = count_r - 1'b1;
  assign last_addr  = count_dec[ADDR_W-1:0];
  assign in_range   = (pos_ext < cnt_ext) && (pos_ext < EXT_W'(CAPACITY));
  assign is_full    = (count_r == CNT_W'(CAPACITY));
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    count_nxt      = count_r;
    src_nxt        = src_r;
    res_word_nxt   = res_word_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = pos_addr;
    ram_wr_data    = word_r;
    ram_rd_addr    = pos_addr;
    count_wide     = cnt_ext;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_req_type;
          pos_nxt   = in_position;
          word_nxt  = in_word_in;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_word_nxt   = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_FINISH;
        case (kind_r)
          REQ_GET: begin
            if (in_range) begin
              state_nxt = S_GET_WAIT;
            end else begin
              res_status_nxt = ST_BAD_INDEX;
            end
          end
          REQ_SET: begin
            if (in_range) begin
              ram_wr_en = 1'b1;
            end else begin
              res_status_nxt = ST_BAD_INDEX;
            end
          end
          REQ_APPEND: begin
            if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = cnt_addr;
              count_nxt   = count_r + 1'b1;
            end
          end
          REQ_INSERT: begin
            if (!in_range) begin
              res_status_nxt = ST_BAD_INDEX;
            end else if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_rd_addr = last_addr;
              src_nxt     = last_addr;
              state_nxt   = S_SHIFT;
            end
          end
          default: begin
            res_status_nxt = ST_BAD_INDEX;
          end
        endcase
      end
      S_GET_WAIT: begin
        res_word_nxt = ram_rd_data;
        state_nxt    = S_FINISH;
      end
      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = src_r + 1'b1;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = src_r - 1'b1;
        if (src_r == pos_addr) begin
          state_nxt = S_INS_WR;
        end else begin
          src_nxt = src_r - 1'b1;
        end
      end
      S_INS_WR: begin
        ram_wr_en = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          count_wide     = cnt_ext;
          out_valid_nxt  = 1'b1;
          out_word_nxt   = res_word_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_wide[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    src_r        <= src_nxt;
    res_word_r   <= res_word_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_word_out  = out_word_r;
  assign out_status    = out_status_r;
  assign out_count_out = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1))
    else $error("element count changed by more than one");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_word_r == '0))
    else $error("refused request returned nonzero data");

  a_shift_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((kind_r == REQ_INSERT) && (src_r >= pos_addr)))
    else $error("shift outside a valid insert");

endmodule
